// ----- sv/hsfr_pkg.sv -----
package hsfr_pkg;

  // Widest frame position that the result port can carry
  localparam int unsigned IdxW = 6;

  // Configuration register indexes (byte address bit 2)
  localparam logic [0:0] REG_HDR_FIRST  = 1'b0;
  localparam logic [0:0] REG_HDR_SECOND = 1'b1;

  localparam logic [7:0] HDR_FIRST_RST  = 8'd170;
  localparam logic [7:0] HDR_SECOND_RST = 8'd85;

  // Byte write into the frame buffer memory
  typedef struct packed {
    logic            en;
    logic            buf_sel;
    logic [IdxW-1:0] idx;
    logic [7:0]      data;
  } hsfr_wr_t;

  // Buffer handed back by the readout side
  typedef struct packed {
    logic en;
    logic buf_sel;
  } hsfr_rel_t;

endpackage

// ----- sv/hsfr_front.sv -----
module hsfr_front #(
  parameter int unsigned FRAME_LEN = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rx_valid_i,
  input  logic [7:0]       rx_byte_i,
  output logic             rx_ready_o,
  input  logic [7:0]       header_first_i,
  input  logic [7:0]       header_second_i,
  output hsfr_pkg::hsfr_wr_t  wr_o,
  output logic             push_o,
  output logic             push_buf_o,
  input  hsfr_pkg::hsfr_rel_t rel_i
);

  localparam int unsigned AW = $clog2(FRAME_LEN);
  localparam logic [AW-1:0] LastPos = AW'(FRAME_LEN - 1);

  logic [AW-1:0] pos_q, pos_d;
  logic [7:0]    sum_q, sum_d;
  logic          wr_sel_q, wr_sel_d;
  logic [1:0]    busy_q, busy_d;
  logic          accept;
  logic          push;

  assign rx_ready_o = !busy_q[wr_sel_q];
  assign accept     = rx_valid_i && rx_ready_o;

  // Classify the byte by its position and track the running sum
  always_comb begin
    pos_d = pos_q;
    sum_d = sum_q;
    push  = 1'b0;
    if (accept) begin
      if (pos_q == '0) begin
        pos_d = (rx_byte_i == header_first_i) ? AW'(1) : '0;
        sum_d = (rx_byte_i == header_first_i) ? rx_byte_i : 8'd0;
      end else if (pos_q == AW'(1) && LastPos != AW'(1)) begin
        pos_d = (rx_byte_i == header_second_i) ? AW'(2) : '0;
        sum_d = (rx_byte_i == header_second_i) ? sum_q + rx_byte_i : 8'd0;
      end else if (pos_q < LastPos) begin
        pos_d = pos_q + AW'(1);
        sum_d = sum_q + rx_byte_i;
      end else begin
        // checksum byte: hand the buffer on when it matches, restart anyway
        push  = (pos_q == LastPos) && (rx_byte_i == sum_q);
        pos_d = '0;
        sum_d = 8'd0;
      end
    end
  end

  always_comb begin
    wr_sel_d = push ? !wr_sel_q : wr_sel_q;
    busy_d   = busy_q;
    if (rel_i.en) begin
      busy_d[rel_i.buf_sel] = 1'b0;
    end
    if (push) begin
      busy_d[wr_sel_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      sum_q    <= 8'd0;
      wr_sel_q <= 1'b0;
      busy_q   <= 2'b00;
    end else begin
      pos_q    <= pos_d;
      sum_q    <= sum_d;
      wr_sel_q <= wr_sel_d;
      busy_q   <= busy_d;
    end
  end

  assign wr_o.en      = accept;
  assign wr_o.buf_sel = wr_sel_q;
  assign wr_o.idx     = hsfr_pkg::IdxW'(pos_q);
  assign wr_o.data    = rx_byte_i;
  assign push_o       = push;
  assign push_buf_o   = wr_sel_q;

  // a completed frame never lands in a buffer still owned by readout
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> busy_q[$past(wr_sel_q)] && (wr_sel_q != $past(wr_sel_q)))
    else $error("frame handoff did not claim its buffer");

endmodule

// ----- sv/hsfr_queue.sv -----
module hsfr_queue (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  logic push_data_i,
  input  logic pop_i,
  output logic pop_data_o,
  output logic empty_o
);

  logic [1:0] ent_q;
  logic       rd_ptr_q;
  logic       wr_ptr_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= 1'b0;
      wr_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  assign pop_data_o = ent_q[rd_ptr_q];
  assign empty_o    = (cnt_q == 2'd0);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> cnt_q != 2'd2)
    else $error("frame queue overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != 2'd0)
    else $error("frame queue underflow");

endmodule

// ----- sv/hsfr_back.sv -----
module hsfr_back #(
  parameter int unsigned FRAME_LEN = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hsfr_pkg::hsfr_wr_t  wr_i,
  input  logic                tok_valid_i,
  input  logic                tok_i,
  output logic                pop_o,
  output hsfr_pkg::hsfr_rel_t rel_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          frame_byte_o,
  output logic [5:0]          byte_index_o,
  output logic                last_o
);

  localparam int unsigned AW = $clog2(FRAME_LEN);
  localparam int unsigned MemDepth = 2 ** (AW + 1);
  localparam logic [AW-1:0] LastPos = AW'(FRAME_LEN - 1);

  logic [7:0]    frame_mem_q [MemDepth];
  logic          active_q, active_d;
  logic          buf_q, buf_d;
  logic [AW-1:0] rd_idx_q, rd_idx_d;
  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_byte_q;
  logic [AW-1:0] out_idx_q;
  logic          out_last_q;
  logic          issue;
  logic          rd_last;

  assign issue   = active_q && (!out_valid_q || out_ready_i);
  assign rd_last = (rd_idx_q == LastPos);
  assign pop_o   = !active_q && tok_valid_i;

  always_comb begin
    active_d    = active_q;
    buf_d       = buf_q;
    rd_idx_d    = rd_idx_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (pop_o) begin
      active_d = 1'b1;
      buf_d    = tok_i;
      rd_idx_d = '0;
    end
    if (issue) begin
      out_valid_d = 1'b1;
      rd_idx_d    = rd_idx_q + AW'(1);
      if (rd_last) begin
        active_d = 1'b0;
      end
    end
  end

  // Write from the front, read straight into the output register
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      frame_mem_q[{wr_i.buf_sel, wr_i.idx[AW-1:0]}] <= wr_i.data;
    end
    if (issue) begin
      out_byte_q <= frame_mem_q[{buf_q, rd_idx_q}];
      out_idx_q  <= rd_idx_q;
      out_last_q <= rd_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      buf_q       <= 1'b0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      buf_q       <= buf_d;
      rd_idx_q    <= rd_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign rel_o.en      = issue && rd_last;
  assign rel_o.buf_sel = buf_q;
  assign out_valid_o   = out_valid_q;
  assign frame_byte_o  = out_byte_q;
  assign byte_index_o  = 6'(out_idx_q);
  assign last_o        = out_last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |-> rd_idx_q <= LastPos)
    else $error("readout index ran past the frame");

endmodule

// ----- sv/header_sum_frame_receiver.sv -----
// Fixed-length frame receiver: takes one received byte per request, checks
// bytes 0 and 1 against header_first/header_second, and checks the final byte
// of a FRAME_LEN-byte frame against the 8-bit sum of all earlier bytes. A good
// frame is sent out as FRAME_LEN results (frame_byte, byte_index, last); a
// header or checksum mismatch drops the partial frame silently, and the
// failing byte is not retried as a new header. Bytes are taken one per cycle
// while a frame buffer is free; the store holds two frames, so input stalls
// only when two validated frames are still waiting to go out. A frame's buffer
// number passes through the frame queue and the readout start before its first
// byte is registered at the output; readout then runs at one result per cycle
// while the output is not held back, with a gap in the output between frames
// that are read out back to back. The headers are written over an APB-style
// port (header_first at byte address 0, header_second at 4); the user must
// write them only while the block is idle, which the block itself does not
// enforce. No clearing pass follows reset.
module header_sum_frame_receiver #(
  parameter int unsigned FRAME_LEN = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Received byte requests
  input  logic        rx_valid_i,
  output logic        rx_ready_o,
  input  logic [7:0]  rx_byte_i,
  // Validated frame bytes
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  frame_byte_o,
  output logic [5:0]  byte_index_o,
  output logic        last_o,
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0] hdr_first_q;
  logic [7:0] hdr_second_q;
  logic       cfg_wr;

  hsfr_pkg::hsfr_wr_t  wr;
  hsfr_pkg::hsfr_rel_t rel;
  logic push;
  logic push_buf;
  logic pop;
  logic tok;
  logic q_empty;

  // Register file: always ready, write on the access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_first_q  <= hsfr_pkg::HDR_FIRST_RST;
      hdr_second_q <= hsfr_pkg::HDR_SECOND_RST;
    end else if (cfg_wr) begin
      if (paddr[2:2] == hsfr_pkg::REG_HDR_FIRST) begin
        hdr_first_q <= pwdata[7:0];
      end else begin
        hdr_second_q <= pwdata[7:0];
      end
    end
  end

  always_comb begin
    if (paddr[2:2] == hsfr_pkg::REG_HDR_SECOND) begin
      prdata = {24'd0, hdr_second_q};
    end else begin
      prdata = {24'd0, hdr_first_q};
    end
  end

  // Front: position tracking, header and checksum checks, buffer writes
  hsfr_front #(
    .FRAME_LEN (FRAME_LEN)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .rx_valid_i      (rx_valid_i),
    .rx_byte_i       (rx_byte_i),
    .rx_ready_o      (rx_ready_o),
    .header_first_i  (hdr_first_q),
    .header_second_i (hdr_second_q),
    .wr_o            (wr),
    .push_o          (push),
    .push_buf_o      (push_buf),
    .rel_i           (rel)
  );

  // Queue of validated frames (buffer numbers) awaiting readout
  hsfr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_buf),
    .pop_i       (pop),
    .pop_data_o  (tok),
    .empty_o     (q_empty)
  );

  // Back: frame buffer memory and byte-by-byte readout
  hsfr_back #(
    .FRAME_LEN (FRAME_LEN)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_i         (wr),
    .tok_valid_i  (!q_empty),
    .tok_i        (tok),
    .pop_o        (pop),
    .rel_o        (rel),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .frame_byte_o (frame_byte_o),
    .byte_index_o (byte_index_o),
    .last_o       (last_o)
  );

endmodule

// ----- tb/header_sum_frame_receiver_test.sv -----
`timescale 1ns / 100ps

module header_sum_frame_receiver_test;

  localparam int unsigned FRAME_LEN = 16;
  // Two frames can be buffered, so leave plenty of margin before touching the
  // headers or ending the run
  localparam int unsigned DRAIN_CYCLES = 4 * FRAME_LEN;
  localparam int unsigned PHASE_BYTES = 50;
  localparam int unsigned NUM_PHASES = 5;

  // One byte of a validated frame as it should leave the block
  typedef struct packed {
    logic [7:0] data;
    logic [5:0] idx;
    logic       last;
  } frame_beat_t;

  // Kinds of byte sequences the stimulus is built from
  typedef enum logic [2:0] {
    SEQ_GOOD,
    SEQ_BAD_SUM,
    SEQ_BAD_FIRST,
    SEQ_BAD_SECOND,
    SEQ_NOISE
  } rx_seq_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic        rx_valid = 1'b0;
  logic        rx_ready;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  frame_byte;
  logic [5:0]  byte_index;
  logic        last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  // Bytes waiting to be offered, and frame bytes the block still owes
  logic [7:0]  rx_byte_q[$];
  frame_beat_t owed_beats[$];

  // Receiver state as predicted by the testbench
  logic [7:0] hdr_first_cfg = hsfr_pkg::HDR_FIRST_RST;
  logic [7:0] hdr_second_cfg = hsfr_pkg::HDR_SECOND_RST;
  int unsigned frame_pos = 0;
  logic [7:0] frame_sum = 8'h00;
  logic [7:0] frame_buf[FRAME_LEN];

  int unsigned mismatch_count = 0;
  int unsigned rx_gap = 0;
  int unsigned out_stall = 0;
  logic calm = 1'b0;

  header_sum_frame_receiver #(
    .FRAME_LEN(FRAME_LEN)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_valid_i  (rx_valid),
    .rx_ready_o  (rx_ready),
    .rx_byte_i   (rx_byte),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .frame_byte_o(frame_byte),
    .byte_index_o(byte_index),
    .last_o      (last),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic log_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Advance the frame tracker by one received byte; on a good checksum,
  // queue the whole frame as owed results
  task automatic absorb_rx_byte(input logic [7:0] b);
    logic [7:0] prior;
    frame_beat_t beat;
    prior = frame_sum;
    if (frame_pos >= FRAME_LEN) begin
      frame_pos = 0;
      frame_sum = 8'h00;
    end else begin
      frame_buf[frame_pos] = b;
      frame_sum = frame_sum + b;
      if (frame_pos == 0) begin
        // No resync: a failing byte is dropped, not retried as a header
        if (b == hdr_first_cfg) frame_pos = 1;
        else frame_sum = 8'h00;
      end else if (frame_pos == 1) begin
        if (b == hdr_second_cfg) frame_pos = 2;
        else begin
          frame_pos = 0;
          frame_sum = 8'h00;
        end
      end else if (frame_pos < FRAME_LEN - 1) begin
        frame_pos++;
      end else begin
        // Checksum byte: compare against the sum of everything before it
        if (b == prior) begin
          for (int k = 0; k < FRAME_LEN; k++) begin
            beat.data = frame_buf[k];
            beat.idx = 6'(k);
            beat.last = (k == FRAME_LEN - 1);
            owed_beats.push_back(beat);
          end
        end
        frame_pos = 0;
        frame_sum = 8'h00;
      end
    end
  endtask

  // Driver: offer queued bytes, hold each request until taken, idle in bursts
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rx_valid && rx_ready) absorb_rx_byte(rx_byte);
      if (!(rx_valid && !rx_ready)) begin
        if (rx_gap > 0) begin
          rx_gap--;
          rx_valid <= 1'b0;
        end else if (rx_byte_q.size() > 0) begin
          rx_valid <= 1'b1;
          rx_byte <= rx_byte_q.pop_front();
          if (!calm && $urandom_range(0, 5) == 0) rx_gap = $urandom_range(1, 8);
        end else begin
          rx_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted frame byte against the oldest owed one,
  // and stall the output side in bursts
  always @(posedge clk_i) begin
    frame_beat_t want;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (owed_beats.size() == 0) begin
          log_mismatch($sformatf("unexpected frame byte %02h idx %0d", frame_byte,
                                 byte_index));
        end else begin
          want = owed_beats.pop_front();
          if (frame_byte !== want.data)
            log_mismatch($sformatf("frame_byte %02h, want %02h (idx %0d)", frame_byte,
                                   want.data, want.idx));
          if (byte_index !== want.idx)
            log_mismatch($sformatf("byte_index %0d, want %0d", byte_index, want.idx));
          if (last !== want.last)
            log_mismatch($sformatf("last %0b, want %0b (idx %0d)", last, want.last,
                                   want.idx));
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) out_stall = $urandom_range(1, 8);
      end
    end
  end

  // Write one header register over the config port; the predictor follows
  // at the same edge the block takes the write
  task automatic write_header(input logic [0:0] reg_sel, input logic [7:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_sel, 2'b00};
    pwdata <= {24'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (reg_sel == hsfr_pkg::REG_HDR_FIRST) hdr_first_cfg = value;
    else hdr_second_cfg = value;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Wait until every byte is taken and every owed frame byte has come out,
  // then let the block finish any frame it is still checking
  task automatic wait_drained();
    do begin
      @(posedge clk_i);
      #1;
    end while (rx_byte_q.size() > 0 || rx_valid || owed_beats.size() > 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_payload();
    case ($urandom_range(0, 9))
      0: pick_payload = 8'h00;
      1: pick_payload = 8'hFF;
      default: pick_payload = 8'($urandom);
    endcase
  endfunction

  // Queue one sequence built against the current header settings
  task automatic queue_sequence(input rx_seq_e kind);
    logic [7:0] b;
    logic [7:0] sum;
    case (kind)
      SEQ_NOISE: begin
        repeat ($urandom_range(1, 3)) rx_byte_q.push_back(8'($urandom));
      end
      SEQ_BAD_FIRST: begin
        do b = 8'($urandom); while (b == hdr_first_cfg);
        rx_byte_q.push_back(b);
      end
      SEQ_BAD_SECOND: begin
        rx_byte_q.push_back(hdr_first_cfg);
        do b = 8'($urandom); while (b == hdr_second_cfg);
        rx_byte_q.push_back(b);
      end
      default: begin
        rx_byte_q.push_back(hdr_first_cfg);
        rx_byte_q.push_back(hdr_second_cfg);
        sum = hdr_first_cfg + hdr_second_cfg;
        for (int k = 2; k < FRAME_LEN - 1; k++) begin
          b = pick_payload();
          rx_byte_q.push_back(b);
          sum = sum + b;
        end
        // Break the checksum by a nonzero offset for a bad frame
        if (kind == SEQ_BAD_SUM) sum = sum + 8'($urandom_range(1, 255));
        rx_byte_q.push_back(sum);
      end
    endcase
  endtask

  function automatic rx_seq_e pick_sequence();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 12) pick_sequence = SEQ_GOOD;
    else if (r < 15) pick_sequence = SEQ_BAD_SUM;
    else if (r < 17) pick_sequence = SEQ_BAD_FIRST;
    else if (r < 18) pick_sequence = SEQ_BAD_SECOND;
    else pick_sequence = SEQ_NOISE;
  endfunction

  // Stimulus
  initial begin
    logic [7:0] phase_first[NUM_PHASES];
    logic [7:0] phase_second[NUM_PHASES];
    logic [7:0] sum;
    logic [7:0] directed_payload[5];
    int unsigned start_size;
    int unsigned queued;

    phase_first = '{8'h00, 8'hFF, 8'($urandom), 8'h5A, hsfr_pkg::HDR_FIRST_RST};
    phase_second = '{8'hFF, 8'h00, 8'($urandom), 8'h5A, hsfr_pkg::HDR_SECOND_RST};
    directed_payload = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset headers: a good frame whose sum wraps,
    // with payload extremes
    rx_byte_q.push_back(hsfr_pkg::HDR_FIRST_RST);
    rx_byte_q.push_back(hsfr_pkg::HDR_SECOND_RST);
    sum = hsfr_pkg::HDR_FIRST_RST + hsfr_pkg::HDR_SECOND_RST;
    for (int k = 2; k < FRAME_LEN - 1; k++) begin
      rx_byte_q.push_back(k < 7 ? directed_payload[k - 2] : 8'hFF);
      sum = sum + (k < 7 ? directed_payload[k - 2] : 8'hFF);
    end
    rx_byte_q.push_back(sum);
    // Header mismatch on the first byte: the second header value in its place
    rx_byte_q.push_back(hsfr_pkg::HDR_SECOND_RST);
    // Header mismatch on the second byte: a repeated first header byte
    rx_byte_q.push_back(hsfr_pkg::HDR_FIRST_RST);
    rx_byte_q.push_back(hsfr_pkg::HDR_FIRST_RST);
    wait_drained();

    // Random part, one header setting per phase, the extremes among them;
    // drop all idling in the final phase
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_header(hsfr_pkg::REG_HDR_FIRST, phase_first[p]);
      write_header(hsfr_pkg::REG_HDR_SECOND, phase_second[p]);
      if (p == NUM_PHASES - 1) calm = 1'b1;
      queued = 0;
      while (queued < PHASE_BYTES) begin
        start_size = rx_byte_q.size();
        queue_sequence(pick_sequence());
        queued += rx_byte_q.size() - start_size;
      end
      wait_drained();
    end

    if (owed_beats.size() != 0)
      log_mismatch($sformatf("%0d frame bytes never came out", owed_beats.size()));
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Run limit, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/hsfr_pkg.sv
sv/hsfr_front.sv
sv/hsfr_queue.sv
sv/hsfr_back.sv
sv/header_sum_frame_receiver.sv
tb/header_sum_frame_receiver_test.sv
